### src/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg: shared types and constants for the sorted insert byte queue
// Capacity, widths, operation and status codes, and the control word that
// the queue front end broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package siq_pkg;

  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 8;
  localparam int OCC_W    = 5;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to all cells for one beat.
  typedef struct packed {
    logic insert_en;  // append or ordered insert goes ahead this cycle
    logic ordered;    // insert position follows the compare chain
    logic pop_en;     // pop goes ahead this cycle
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/siq_cell.sv
// ----------------------------------------------------------------------------
// siq_cell: one storage cell of the shift-register queue
// Holds one byte, compares it against the incoming byte, and takes its own
// value, the new byte, or a neighbor's byte each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module siq_cell (
  input  wire logic                        clk,
  input  wire siq_pkg::cell_ctrl_t         ctrl,
  input  wire logic                        occupied,  // this cell holds an entry
  input  wire logic                        tail,      // this cell is the first free one
  input  wire logic                        found_in,  // an earlier cell took the insert point
  input  wire logic [siq_pkg::DATA_W-1:0]  data,
  input  wire logic [siq_pkg::DATA_W-1:0]  left_value,
  input  wire logic [siq_pkg::DATA_W-1:0]  right_value,
  output logic      [siq_pkg::DATA_W-1:0]  value,
  output logic      [siq_pkg::DATA_W-1:0]  value_nxt,
  output logic                             found_out
);

  logic [siq_pkg::DATA_W-1:0] value_r;
  logic                       ge;

  // This cell holds an entry not less than the new byte (ordered insert only).
  assign ge        = ctrl.ordered & occupied & (value_r >= data);
  assign found_out = found_in | ge;
  assign value     = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.insert_en) begin
      if (found_in && (occupied || tail)) begin
        value_nxt = left_value;
      end else if (!found_in && (ge || tail)) begin
        value_nxt = data;
      end
    end else if (ctrl.pop_en && occupied) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

### src/sorted_insert_byte_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_byte_queue_core: bounded byte queue with ordered insert
// A row of storage cells with append, ordered insert and pop-head operations.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_mode, in_data_in) carries one
//   operation per beat: append at tail, ordered insert, or pop head. The
//   result channel (out_valid, out_stall, out_*) returns exactly one beat per
//   operation with the popped byte, the new head, the occupancy and a status.
//   The result is registered: the output register loads it at the edge that
//   accepts the beat. One operation per cycle is taken while in_stall is low,
//   set by the row of cells, which all compare and shift in the same cycle;
//   the insert point is found by a one-bit chain running through the cells.
//   A single output register holds the result. While it holds a beat that
//   the receiver stalls, in_stall is raised and no operation is taken, so the
//   queue state never runs ahead of the delivered results.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result. Cell contents are not cleared; only cells below the count are
//   ever read, so no clearing pass is needed.
//   An insert into a full queue leaves it unchanged and reports the full
//   status; a pop from an empty queue reports the empty status and zero.
//   The unused mode code changes nothing and reports done.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_byte_queue_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [siq_pkg::DATA_W-1:0]  in_data_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [siq_pkg::DATA_W-1:0]  out_popped_value,
  output logic      [siq_pkg::DATA_W-1:0]  out_head_value,
  output logic      [siq_pkg::OCC_W-1:0]   out_occupancy,
  output logic      [1:0]                  out_status
);

  localparam int CAP = siq_pkg::CAPACITY;
  localparam int CW  = siq_pkg::COUNT_W;
  localparam int DW  = siq_pkg::DATA_W;

  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r;
  logic [DW-1:0]        popped_r, head_r;
  logic [siq_pkg::OCC_W-1:0] occ_r;
  logic [1:0]           status_r;

  logic                 accept;
  logic                 is_insert, is_pop, full, empty;
  siq_pkg::cell_ctrl_t  ctrl;
  logic [1:0]           status_nxt;
  logic [DW-1:0]        popped_nxt, head_nxt;

  logic [DW-1:0]        cell_value [CAP];
  logic [DW-1:0]        cell_nxt   [CAP];
  logic [CAP:0]         found;
  logic [CAP-1:0]       occupied;
  logic [CAP-1:0]       tail;

  // The output register can take a new beat whenever it is empty or being
  // drained this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_insert = (in_mode == siq_pkg::MODE_APPEND) || (in_mode == siq_pkg::MODE_INSERT);
  assign is_pop    = (in_mode == siq_pkg::MODE_POP);
  assign full      = (count_r == CW'(CAP));
  assign empty     = (count_r == '0);

  assign ctrl.insert_en = accept & is_insert & ~full;
  assign ctrl.ordered   = (in_mode == siq_pkg::MODE_INSERT);
  assign ctrl.pop_en    = accept & is_pop & ~empty;

  // Cell 0 never sees an earlier insert point.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [DW-1:0] left_v, right_v;

    // Cells below the count hold entries; the cell at the count is the tail.
    assign occupied[i] = (count_r > CW'(i));
    assign tail[i]     = (count_r == CW'(i));

    if (i == 0) begin : g_first
      assign left_v = in_data_in;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    siq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .tail        (tail[i]),
      .found_in    (found[i]),
      .data        (in_data_in),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .value_nxt   (cell_nxt[i]),
      .found_out   (found[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.insert_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    status_nxt = siq_pkg::ST_DONE;
    if (is_insert && full) begin
      status_nxt = siq_pkg::ST_FULL;
    end else if (is_pop && empty) begin
      status_nxt = siq_pkg::ST_EMPTY;
    end
  end

  assign popped_nxt = ctrl.pop_en ? cell_value[0] : '0;
  assign head_nxt   = (count_nxt != '0) ? cell_nxt[0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload loads only with an accepted beat, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      head_r   <= head_nxt;
      occ_r    <= siq_pkg::OCC_W'(count_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_head_value   = head_r;
  assign out_occupancy    = occ_r;
  assign out_status       = status_r;

  // The count never runs past the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("queue count above capacity");

  // A dropped insert into a full queue leaves the count alone.
  a_full_hold : assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_insert && full |=> count_r == CW'(CAP))
    else $error("full insert changed the count");

  // A pop from a non-empty queue removes exactly one entry.
  a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_pop && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not remove one entry");

  // An empty-pop result never carries a popped byte.
  a_empty_pop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == siq_pkg::ST_EMPTY) |-> popped_r == '0)
    else $error("empty pop reported a value");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_insert_byte_queue_core
// Drives append, ordered insert, pop and the unused mode through the input
// channel with random gaps. It stalls the result channel at random. A
// scoreboard keeps its own copy of the queue and checks every result beat
// field by field.
// ----------------------------------------------------------------------------

module tb;

  // The unused fourth mode code: the block must leave the queue alone.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_OPS     = 700;
  localparam int DRAIN_CYCLES   = 8;    // results come from one output register, so this is ample
  localparam int WATCHDOG_LIMIT = 2000; // far above the longest gap plus the longest stall

  // One expected result beat.
  typedef struct packed {
    logic [siq_pkg::DATA_W-1:0] popped;
    logic [siq_pkg::DATA_W-1:0] head;
    logic [siq_pkg::OCC_W-1:0]  occ;
    logic [1:0]                 status;
  } queue_result_t;

  // Scoreboard: mirrors the queue contents and holds the result beats that
  // are still to come, oldest first.
  class sorted_queue_scoreboard;
    logic [siq_pkg::DATA_W-1:0] cells [siq_pkg::CAPACITY];
    int unsigned                count;
    queue_result_t              pending_results [$];
    int unsigned                errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Applies one accepted operation to the mirror and queues its result.
    function void note_op(logic [1:0] mode, logic [siq_pkg::DATA_W-1:0] data);
      queue_result_t r;
      int unsigned   pos;
      int unsigned   i;
      bit            found;
      r.popped = '0;
      r.status = siq_pkg::ST_DONE;
      case (mode)
        siq_pkg::MODE_APPEND, siq_pkg::MODE_INSERT: begin
          if (count >= siq_pkg::CAPACITY) begin
            r.status = siq_pkg::ST_FULL;
          end else begin
            pos = count;
            if (mode == siq_pkg::MODE_INSERT) begin
              found = 1'b0;
              i = 0;
              // Goes in front of the first entry not less than the new byte,
              // so the new byte goes in front of an equal entry.
              while (!found && i < count) begin
                if (cells[i] >= data) begin
                  pos   = i;
                  found = 1'b1;
                end
                i++;
              end
            end
            for (i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = data;
            count++;
          end
        end
        siq_pkg::MODE_POP: begin
          if (count == 0) begin
            r.status = siq_pkg::ST_EMPTY;
          end else begin
            r.popped = cells[0];
            for (i = 1; i < count; i++) cells[i-1] = cells[i];
            count--;
          end
        end
        default: ;
      endcase
      r.head = (count > 0) ? cells[0] : '0;
      r.occ  = siq_pkg::OCC_W'(count);
      pending_results.push_back(r);
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_result(logic [siq_pkg::DATA_W-1:0] popped,
                               logic [siq_pkg::DATA_W-1:0] head,
                               logic [siq_pkg::OCC_W-1:0] occ, logic [1:0] status);
      queue_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (popped !== e.popped) begin
        $error("popped_value: expected 0x%02h, got 0x%02h", e.popped, popped);
        errors++;
      end
      if (head !== e.head) begin
        $error("head_value: expected 0x%02h, got 0x%02h", e.head, head);
        errors++;
      end
      if (occ !== e.occ) begin
        $error("occupancy: expected %0d, got %0d", e.occ, occ);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  // Clock and block ports. Everything starts at a known value.
  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_mode    = siq_pkg::MODE_APPEND;
  logic [siq_pkg::DATA_W-1:0] in_data_in = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic [siq_pkg::DATA_W-1:0] out_popped_value;
  logic [siq_pkg::DATA_W-1:0] out_head_value;
  logic [siq_pkg::OCC_W-1:0]  out_occupancy;
  logic [1:0]                 out_status;

  sorted_queue_scoreboard sb = new();

  // When set, the matching side runs without gaps for a while.
  bit     in_no_gaps  = 1'b0;
  bit     out_no_gaps = 1'b0;
  int     idle_cycles = 0;

  always #5 clk = ~clk;

  sorted_insert_byte_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_data_in       (in_data_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_value (out_popped_value),
    .out_head_value   (out_head_value),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap(bit no_gaps);
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Byte values: corner bytes and a tiny pool make equal entries common,
  // the rest spans the whole range.
  function automatic logic [siq_pkg::DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'hFF;
          2:       return 8'h7F;
          default: return 8'h80;
        endcase
      end
      1:       return siq_pkg::DATA_W'($urandom_range(0, 3));
      default: return siq_pkg::DATA_W'($urandom);
    endcase
  endfunction

  // Sends one operation beat. It is called at a rising edge and returns at
  // the edge where the beat was accepted. Valid is only lowered when a gap
  // follows, so a back-to-back beat sees a single assignment per edge.
  task automatic send_op(logic [1:0] mode, logic [siq_pkg::DATA_W-1:0] data);
    int gap;
    gap = pick_gap(in_no_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_data_in <= data;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_op(mode, data);
  endtask

  // Result side: stall for a random stretch, then accept for a random
  // stretch. Stall changes only at rising edges, at most once per edge.
  initial begin : out_stall_gen
    int n;
    forever begin
      if ($urandom_range(0, 15) == 0) out_no_gaps = ~out_no_gaps;
      n = pick_gap(out_no_gaps);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Every result beat is checked at the edge that accepts it. All block
  // outputs are read before the edge's updates land, so order in the time
  // step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_popped_value, out_head_value, out_occupancy, out_status);
    end
  end

  // Watchdog: a long run of cycles without any beat on either channel means
  // the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int seg_len;
    int bias;
    int r;
    int k;
    logic [1:0] mode;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Pop and the unused mode on an empty queue come first.
    // A set data byte on the pop shows that it is ignored.
    send_op(siq_pkg::MODE_POP, 8'hFF);
    send_op(MODE_UNUSED, 8'hA5);
    send_op(siq_pkg::MODE_APPEND, 8'h80);
    // An equal byte goes in front of the head.
    send_op(siq_pkg::MODE_INSERT, 8'h80);
    send_op(siq_pkg::MODE_INSERT, 8'h00);
    send_op(siq_pkg::MODE_INSERT, 8'hFF);
    send_op(siq_pkg::MODE_APPEND, 8'h00);
    // Fill up to capacity with ordered inserts.
    for (k = 5; k < siq_pkg::CAPACITY; k++) begin
      send_op(siq_pkg::MODE_INSERT, siq_pkg::DATA_W'($urandom));
    end
    // Both kinds of insert into a full queue are dropped.
    send_op(siq_pkg::MODE_INSERT, 8'h00);
    send_op(siq_pkg::MODE_APPEND, 8'hFF);
    send_op(MODE_UNUSED, 8'h5A);
    send_op(siq_pkg::MODE_POP, 8'h00);
    send_op(siq_pkg::MODE_POP, 8'hFF);

    // Random part, in segments that lean toward filling, draining or
    // neither, so the queue keeps passing through full and empty.
    sent = 0;
    while (sent < RANDOM_OPS) begin
      seg_len    = $urandom_range(10, 60);
      bias       = $urandom_range(0, 2);
      in_no_gaps = ($urandom_range(0, 3) == 0);
      for (k = 0; k < seg_len && sent < RANDOM_OPS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          mode = MODE_UNUSED;
        end else begin
          r = $urandom_range(0, 99);
          if ((bias == 0 && r < 80) || (bias == 1 && r < 20) || (bias == 2 && r < 50)) begin
            mode = ($urandom_range(0, 9) < 3) ? siq_pkg::MODE_APPEND : siq_pkg::MODE_INSERT;
          end else begin
            mode = siq_pkg::MODE_POP;
          end
        end
        send_op(mode, pick_byte());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Wait for the last result beats, then DRAIN_CYCLES more so that a
    // stray extra beat would still be caught.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
